[rtl/core/lu_decomposition_determinant_unit_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef LU_DECOMPOSITION_DETERMINANT_UNIT_MACROS_SVH
`define LU_DECOMPOSITION_DETERMINANT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LU_DET_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lu_det assertion failed");

// Next-cycle implication, disabled during reset.
`define LU_DET_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lu_det assertion failed");

`endif

[rtl/core/lu_det_pkg.sv]
package lu_det_pkg;

    localparam int MAX_ORDER = 8;
    localparam int DIV_STEPS = 48;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [63:0] ONE_DET = 64'sd65536;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_STEP,
        ST_PIV_RD,
        ST_PIV,
        ST_DET_HI,
        ST_DET_LO,
        ST_DET_FIN,
        ST_ROW,
        ST_L_RD,
        ST_L_DIV,
        ST_DIV,
        ST_L_WR,
        ST_COL,
        ST_U_RD,
        ST_A_RD,
        ST_MUL,
        ST_SUB,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // Magnitude of a signed word as an unsigned word.
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Saturate a signed 64-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/lu_det_ram.sv]
module lu_det_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/lu_decomposition_determinant_unit.sv]
// Each element is written while start is high in idle; the final element starts the factorization.
// Elimination time is dominated by the serial restoring divider that forms each L entry; the
// multiplier and the RAM, with one write and one read port, take the rest. Results then follow,
// n*n of them, each read from the RAM and then registered; busy falls in the cycle the last
// one is shown. The receiver cannot stall. Reset (rst_n low, asynchronous) sets n to 8 and
// clears the load position; matrix contents are undefined.
module lu_decomposition_determinant_unit #(
    parameter int MAX_ORDER = lu_det_pkg::MAX_ORDER
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] element_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         matrix_size,
    output logic               result_valid,
    output logic [2:0]         row_index,
    output logic [2:0]         col_index,
    output logic signed [31:0] lower_value,
    output logic signed [31:0] upper_value,
    output logic signed [63:0] determinant,
    output logic               singular,
    output logic               last_entry
);

    localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_ORDER + 1);

    function automatic logic [ADDR_W-1:0] mat_addr(input logic [CNT_W-1:0] row_i,
                                                   input logic [CNT_W-1:0] col_i);
        return ADDR_W'(int'(row_i) * MAX_ORDER + int'(col_i));
    endfunction

    lu_det_pkg::state_t state_reg, state_next;

    logic [3:0]         size_reg, size_next;
    logic [CNT_W-1:0]   lrow_reg, lrow_next, lcol_reg, lcol_next;
    logic [CNT_W-1:0]   k_reg, k_next, i_reg, i_next, j_reg, j_next, ks_reg, ks_next;
    logic signed [63:0] det_reg, det_next;
    logic               sing_reg, sing_next;
    logic signed [31:0] piv_reg, piv_next;
    logic [31:0]        pmag_reg, pmag_next;
    logic [63:0]        hi_reg, hi_next;
    logic [63:0]        mul_reg;
    logic signed [31:0] l_reg, l_next, u_reg, u_next, a_reg, a_next;
    logic [47:0]        num_reg, num_next;
    logic [31:0]        rem_reg, rem_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic               qneg_reg, qneg_next;
    logic               valid_reg, valid_next, last_reg, last_next;
    logic [2:0]         row_reg, row_next, col_reg, col_next;
    logic signed [31:0] lower_reg, lower_next, upper_reg, upper_next;

    logic [CNT_W-1:0]   n, n_m1;
    logic               mem_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        wdata, rdata;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        det_mag, lim, lo_part, m_val, prod_mag;
    logic               det_neg, prod_neg;
    logic signed [63:0] prod_s, diff;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic signed [31:0] lsat;

    // Order in use: zero acts as one, large values clamp to the maximum.
    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(size_reg) > MAX_ORDER)
        begin
            n = CNT_W'(MAX_ORDER);
        end
        else
        begin
            n = CNT_W'(size_reg);
        end
        n_m1 = n - 1'b1;
    end

    // Working matrix; holds L below and U on and above the diagonal in place.
    lu_det_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_work_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Shared multiplier with registered product.
    always_ff @(posedge clk)
    begin
        mul_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Determinant update terms.
    assign det_mag  = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
    assign det_neg  = det_reg[63] ^ piv_reg[31];
    assign lim      = det_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    assign lo_part  = mul_reg >> 16;

    always_comb
    begin
        if (hi_reg[63:47] != 17'd0)
        begin
            m_val = lim;
        end
        else if (((hi_reg << 16) + lo_part) > lim)
        begin
            m_val = lim;
        end
        else
        begin
            m_val = (hi_reg << 16) + lo_part;
        end
    end

    // Elimination update terms.
    assign prod_mag = mul_reg >> 16;
    assign prod_neg = l_reg[31] ^ u_reg[31];
    assign prod_s   = prod_neg ? -$signed(prod_mag) : $signed(prod_mag);
    assign diff     = 64'(a_reg) - prod_s;

    // One restoring divider step.
    assign rem_sh = {rem_reg, num_reg[47]};
    assign rem_ge = rem_sh >= {1'b0, pmag_reg};

    // Saturated signed quotient.
    always_comb
    begin
        if (qneg_reg)
        begin
            lsat = (num_reg > 48'h0000_8000_0000) ? 32'sh8000_0000 : 32'(-num_reg[31:0]);
        end
        else
        begin
            lsat = (num_reg > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(num_reg[31:0]);
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lu_det_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 4'd8;
            lrow_reg  <= '0;
            lcol_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ks_reg    <= '0;
            dcnt_reg  <= '0;
            det_reg   <= lu_det_pkg::ONE_DET;
            sing_reg  <= 1'b0;
        end
        else
        begin
            size_reg  <= size_next;
            lrow_reg  <= lrow_next;
            lcol_reg  <= lcol_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ks_reg    <= ks_next;
            dcnt_reg  <= dcnt_next;
            det_reg   <= det_next;
            sing_reg  <= sing_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        piv_reg   <= piv_next;
        pmag_reg  <= pmag_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        u_reg     <= u_next;
        a_reg     <= a_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        qneg_reg  <= qneg_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        lower_reg <= lower_next;
        upper_reg <= upper_next;
    end

    // Sequencer: next state, register updates and RAM control.
    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        lrow_next  = lrow_reg;
        lcol_next  = lcol_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ks_next    = ks_reg;
        det_next   = det_reg;
        sing_next  = sing_reg;
        piv_next   = piv_reg;
        pmag_next  = pmag_reg;
        hi_next    = hi_reg;
        l_next     = l_reg;
        u_next     = u_reg;
        a_next     = a_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        qneg_next  = qneg_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        row_next   = row_reg;
        col_next   = col_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        mem_we     = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr      = '0;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            lu_det_pkg::ST_IDLE:
            begin
                // A word on start always wins; configuration waits for a free cycle.
                if (start)
                begin
                    mem_we = 1'b1;
                    waddr  = mat_addr(lrow_reg, lcol_reg);
                    wdata  = element_value;
                    if (lcol_reg == n_m1)
                    begin
                        lcol_next = '0;
                        if (lrow_reg == n_m1)
                        begin
                            lrow_next  = '0;
                            k_next     = '0;
                            ks_next    = n;
                            det_next   = lu_det_pkg::ONE_DET;
                            sing_next  = 1'b0;
                            state_next = lu_det_pkg::ST_STEP;
                        end
                        else
                        begin
                            lrow_next = lrow_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        lcol_next = lcol_reg + 1'b1;
                    end
                end
                else if (cfg_valid)
                begin
                    size_next = matrix_size;
                    lrow_next = '0;
                    lcol_next = '0;
                end
            end

            lu_det_pkg::ST_STEP:
            begin
                if (k_reg >= n)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = lu_det_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = lu_det_pkg::ST_PIV_RD;
                end
            end

            lu_det_pkg::ST_PIV_RD:
            begin
                raddr      = mat_addr(k_reg, k_reg);
                state_next = lu_det_pkg::ST_PIV;
            end

            lu_det_pkg::ST_PIV:
            begin
                piv_next  = rdata;
                pmag_next = lu_det_pkg::mag32(rdata);
                if (rdata == 32'd0)
                begin
                    // Zero pivot: elimination stops here.
                    sing_next  = 1'b1;
                    det_next   = '0;
                    ks_next    = k_reg;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = lu_det_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = lu_det_pkg::ST_DET_HI;
                end
            end

            lu_det_pkg::ST_DET_HI:
            begin
                mul_a      = det_mag[63:32];
                mul_b      = pmag_reg;
                state_next = lu_det_pkg::ST_DET_LO;
            end

            lu_det_pkg::ST_DET_LO:
            begin
                hi_next    = mul_reg;
                mul_a      = det_mag[31:0];
                mul_b      = pmag_reg;
                state_next = lu_det_pkg::ST_DET_FIN;
            end

            lu_det_pkg::ST_DET_FIN:
            begin
                det_next   = det_neg ? -$signed(m_val) : $signed(m_val);
                i_next     = k_reg + 1'b1;
                state_next = lu_det_pkg::ST_ROW;
            end

            lu_det_pkg::ST_ROW:
            begin
                if (i_reg >= n)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = lu_det_pkg::ST_STEP;
                end
                else
                begin
                    state_next = lu_det_pkg::ST_L_RD;
                end
            end

            lu_det_pkg::ST_L_RD:
            begin
                raddr      = mat_addr(i_reg, k_reg);
                state_next = lu_det_pkg::ST_L_DIV;
            end

            lu_det_pkg::ST_L_DIV:
            begin
                num_next   = {lu_det_pkg::mag32(rdata), 16'd0};
                rem_next   = '0;
                dcnt_next  = '0;
                qneg_next  = rdata[31] ^ piv_reg[31];
                state_next = lu_det_pkg::ST_DIV;
            end

            lu_det_pkg::ST_DIV:
            begin
                rem_next  = rem_ge ? 32'(rem_sh - {1'b0, pmag_reg}) : rem_sh[31:0];
                num_next  = {num_reg[46:0], rem_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (int'(dcnt_reg) == lu_det_pkg::DIV_STEPS - 1)
                begin
                    state_next = lu_det_pkg::ST_L_WR;
                end
            end

            lu_det_pkg::ST_L_WR:
            begin
                mem_we     = 1'b1;
                waddr      = mat_addr(i_reg, k_reg);
                wdata      = lsat;
                l_next     = lsat;
                j_next     = k_reg + 1'b1;
                state_next = lu_det_pkg::ST_COL;
            end

            lu_det_pkg::ST_COL:
            begin
                if (j_reg >= n)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = lu_det_pkg::ST_ROW;
                end
                else
                begin
                    state_next = lu_det_pkg::ST_U_RD;
                end
            end

            lu_det_pkg::ST_U_RD:
            begin
                raddr      = mat_addr(k_reg, j_reg);
                state_next = lu_det_pkg::ST_A_RD;
            end

            lu_det_pkg::ST_A_RD:
            begin
                u_next     = rdata;
                raddr      = mat_addr(i_reg, j_reg);
                state_next = lu_det_pkg::ST_MUL;
            end

            lu_det_pkg::ST_MUL:
            begin
                a_next     = rdata;
                mul_a      = lu_det_pkg::mag32(l_reg);
                mul_b      = lu_det_pkg::mag32(u_reg);
                state_next = lu_det_pkg::ST_SUB;
            end

            lu_det_pkg::ST_SUB:
            begin
                mem_we     = 1'b1;
                waddr      = mat_addr(i_reg, j_reg);
                wdata      = lu_det_pkg::sat32(diff);
                j_next     = j_reg + 1'b1;
                state_next = lu_det_pkg::ST_COL;
            end

            lu_det_pkg::ST_OUT_RD:
            begin
                raddr      = mat_addr(i_reg, j_reg);
                state_next = lu_det_pkg::ST_OUT;
            end

            lu_det_pkg::ST_OUT:
            begin
                // Split the in-place word into its L and U entries.
                valid_next = 1'b1;
                row_next   = 3'(i_reg);
                col_next   = 3'(j_reg);
                if (sing_reg && (j_reg >= ks_reg))
                begin
                    lower_next = '0;
                end
                else if (i_reg > j_reg)
                begin
                    lower_next = rdata;
                end
                else if (i_reg == j_reg)
                begin
                    lower_next = lu_det_pkg::ONE_Q16;
                end
                else
                begin
                    lower_next = '0;
                end
                if ((sing_reg && (i_reg >= ks_reg)) || (j_reg < i_reg))
                begin
                    upper_next = '0;
                end
                else
                begin
                    upper_next = rdata;
                end
                state_next = lu_det_pkg::ST_OUT_RD;
                if (j_reg == n_m1)
                begin
                    j_next = '0;
                    if (i_reg == n_m1)
                    begin
                        last_next  = 1'b1;
                        state_next = lu_det_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = lu_det_pkg::ST_IDLE;
            end
        endcase
    end

    // Port outputs; a size write is taken only in an idle cycle without a word.
    assign busy         = (state_reg != lu_det_pkg::ST_IDLE);
    assign cfg_ready    = (state_reg == lu_det_pkg::ST_IDLE) && !start;
    assign result_valid = valid_reg;
    assign last_entry   = last_reg;
    assign row_index    = row_reg;
    assign col_index    = col_reg;
    assign lower_value  = lower_reg;
    assign upper_value  = upper_reg;
    assign determinant  = det_reg;
    assign singular     = sing_reg;

endmodule

[rtl/core/lu_det_checker.sv]
`include "lu_decomposition_determinant_unit_macros.svh"

module lu_det_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               cfg_ready,
    input logic               result_valid,
    input logic               last_entry,
    input logic               singular,
    input logic signed [63:0] determinant
);

    // Configuration is only taken while no run is in progress.
    `LU_DET_ASSERT_IMP(a_cfg_only_idle, clk, rst_n, cfg_ready, !busy)

    // Every result word comes out of a running factorization.
    `LU_DET_ASSERT_IMP(a_word_from_run, clk, rst_n, result_valid, $past(busy))

    // The run keeps going until its final word.
    `LU_DET_ASSERT_NXT(a_run_continues, clk, rst_n, result_valid && !last_entry, busy)

    // A singular matrix reports a zero determinant.
    `LU_DET_ASSERT_IMP(a_singular_zero, clk, rst_n, result_valid && singular, determinant == 64'sd0)

endmodule

bind lu_decomposition_determinant_unit lu_det_checker u_lu_det_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .cfg_ready    (cfg_ready),
    .result_valid (result_valid),
    .last_entry   (last_entry),
    .singular     (singular),
    .determinant  (determinant)
);
